>>> rtl/rpu_pkg.sv
`timescale 1ns / 1ps

package rpu_pkg;

  localparam int RAW_W  = 64;
  localparam int FMT_W  = 3;
  localparam int COMP_W = 8;
  localparam int NAT_W  = 10;

  localparam logic [FMT_W-1:0] FMT_YVYU     = 3'd0;
  localparam logic [FMT_W-1:0] FMT_Y210     = 3'd1;
  localparam logic [FMT_W-1:0] FMT_BGRA8    = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGBA8    = 3'd3;
  localparam logic [FMT_W-1:0] FMT_P2101010 = 3'd4;

  // n*255+511 for a 10-bit sample
  localparam int RND_W = 18;

endpackage

>>> rtl/rpu_if.sv
`timescale 1ns / 1ps

interface rpu_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [rpu_pkg::FMT_W-1:0] pixel_format;

  modport source (output valid, output pixel_format, input ready);
  modport sink   (input valid, input pixel_format, output ready);
endinterface

interface rpu_raw_if;
  logic                      valid;
  logic                      ready;
  logic [rpu_pkg::RAW_W-1:0] raw_word;
  logic                      odd_pixel;

  modport source (output valid, output raw_word, output odd_pixel, input ready);
  modport sink   (input valid, input raw_word, input odd_pixel, output ready);
endinterface

interface rpu_argb_if;
  logic                       valid;
  logic                       ready;
  logic [rpu_pkg::COMP_W-1:0] red_out;
  logic [rpu_pkg::COMP_W-1:0] green_out;
  logic [rpu_pkg::COMP_W-1:0] blue_out;
  logic [rpu_pkg::COMP_W-1:0] alpha_out;
  logic [rpu_pkg::NAT_W-1:0]  native_first;
  logic [rpu_pkg::NAT_W-1:0]  native_second;
  logic [rpu_pkg::NAT_W-1:0]  native_third;
  logic [rpu_pkg::COMP_W-1:0] native_alpha;
  logic                       padding_clear;

  modport source (
    output valid, output red_out, output green_out, output blue_out, output alpha_out,
    output native_first, output native_second, output native_third, output native_alpha,
    output padding_clear, input ready
  );
  modport sink (
    input valid, input red_out, input green_out, input blue_out, input alpha_out,
    input native_first, input native_second, input native_third, input native_alpha,
    input padding_clear, output ready
  );
endinterface

>>> rtl/raw_pixel_unpack_to_argb.sv
`timescale 1ns / 1ps

// Raw pixel unpacker: takes one raw little-endian pixel word per clock and returns
// preview ARGB8888 plus the native samples, in the format held in pixel_format
// (YVYU, Y210, BGRA8, RGBA8, packed 2:10:10:10). Throughput is one pixel per clock;
// the pipe holds the unpack stage, the BT.601 multiply and 10-to-8
// rounding stage, and the sum/saturate stage that loads the output register.
// Backpressure stalls the whole pipe without loss. The config channel is always
// ready; change pixel_format only when no pixels are in flight.
module raw_pixel_unpack_to_argb (
  input logic         clk,
  input logic         rst,
  rpu_cfg_if.sink     cfg,
  rpu_raw_if.sink     raw,
  rpu_argb_if.source  argb
);

  logic [rpu_pkg::FMT_W-1:0] pixel_format;

  logic adv1, adv2, adv3;

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] w0, w1, w2, w3;
  logic [9:0]  u_n1, u_n2, u_n3;
  logic [7:0]  u_na;
  logic        u_pad;
  logic [7:0]  y8, cu8, cv8;

  logic                      s1_valid;
  logic [rpu_pkg::FMT_W-1:0] s1_fmt;
  logic [9:0]                s1_n1, s1_n2, s1_n3;
  logic [7:0]                s1_na;
  logic                      s1_pad;
  logic [7:0]                s1_c;
  logic signed [8:0]         s1_d, s1_e;
  logic [rpu_pkg::RND_W-1:0] s1_x1, s1_x2, s1_x3;

  logic                      s2_valid;
  logic [rpu_pkg::FMT_W-1:0] s2_fmt;
  logic [9:0]                s2_n1, s2_n2, s2_n3;
  logic [7:0]                s2_na;
  logic                      s2_pad;

  logic [7:0] csc_r, csc_g, csc_b;
  logic [7:0] rnd_r, rnd_g, rnd_b;

  logic       s3_valid;
  logic [7:0] r_next, g_next, b_next, a_next, na_next;
  logic [9:0] n1_next, n2_next, n3_next;
  logic       pad_next;

  function automatic logic [rpu_pkg::RND_W-1:0] rnd_num(input logic [9:0] n);
    return {n, 8'b0} - {8'b0, n} + 18'd511;
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= rpu_pkg::FMT_YVYU;
    end else if (cfg.valid) begin
      pixel_format <= cfg.pixel_format;
    end
  end

  assign adv3      = !s3_valid || argb.ready;
  assign adv2      = !s2_valid || adv3;
  assign adv1      = !s1_valid || adv2;
  assign raw.ready = adv1;

  // stage 1: unpack
  assign b0 = raw.raw_word[7:0];
  assign b1 = raw.raw_word[15:8];
  assign b2 = raw.raw_word[23:16];
  assign b3 = raw.raw_word[31:24];
  assign w0 = raw.raw_word[15:0];
  assign w1 = raw.raw_word[31:16];
  assign w2 = raw.raw_word[47:32];
  assign w3 = raw.raw_word[63:48];

  always_comb begin
    u_n1  = '0;
    u_n2  = '0;
    u_n3  = '0;
    u_na  = '0;
    u_pad = 1'b0;
    y8    = '0;
    cu8   = 8'd128;
    cv8   = 8'd128;
    unique case (pixel_format)
      rpu_pkg::FMT_YVYU: begin
        u_n1 = {2'b0, raw.odd_pixel ? b2 : b0};
        u_n2 = {2'b0, b3};
        u_n3 = {2'b0, b1};
        y8   = u_n1[7:0];
        cu8  = b3;
        cv8  = b1;
      end
      rpu_pkg::FMT_Y210: begin
        u_n1  = raw.odd_pixel ? w2[15:6] : w0[15:6];
        u_n2  = w1[15:6];
        u_n3  = w3[15:6];
        y8    = u_n1[9:2];
        cu8   = u_n2[9:2];
        cv8   = u_n3[9:2];
        u_pad = ((w0[5:0] | w1[5:0] | w2[5:0] | w3[5:0]) == 6'd0);
      end
      rpu_pkg::FMT_BGRA8: begin
        u_n3 = {2'b0, b0};
        u_n2 = {2'b0, b1};
        u_n1 = {2'b0, b2};
        u_na = b3;
      end
      rpu_pkg::FMT_RGBA8: begin
        u_n1 = {2'b0, b0};
        u_n2 = {2'b0, b1};
        u_n3 = {2'b0, b2};
        u_na = b3;
      end
      rpu_pkg::FMT_P2101010: begin
        u_n1 = raw.raw_word[9:0];
        u_n2 = raw.raw_word[19:10];
        u_n3 = raw.raw_word[29:20];
        u_na = {6'b0, raw.raw_word[31:30]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= raw.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_fmt <= pixel_format;
      s1_n1  <= u_n1;
      s1_n2  <= u_n2;
      s1_n3  <= u_n3;
      s1_na  <= u_na;
      s1_pad <= u_pad;
      s1_c   <= (y8 < 8'd16) ? 8'd0 : y8 - 8'd16;
      s1_d   <= $signed({1'b0, cu8}) - 9'sd128;
      s1_e   <= $signed({1'b0, cv8}) - 9'sd128;
      s1_x1  <= rnd_num(u_n1);
      s1_x2  <= rnd_num(u_n2);
      s1_x3  <= rnd_num(u_n3);
    end
  end

  // stage 2: products and reciprocal estimate
  rpu_csc u_csc (
    .clk   (clk),
    .en    (adv2),
    .c     (s1_c),
    .d     (s1_d),
    .e     (s1_e),
    .red   (csc_r),
    .green (csc_g),
    .blue  (csc_b)
  );

  rpu_round10 u_rnd_r (.clk(clk), .en(adv2), .x(s1_x1), .q(rnd_r));
  rpu_round10 u_rnd_g (.clk(clk), .en(adv2), .x(s1_x2), .q(rnd_g));
  rpu_round10 u_rnd_b (.clk(clk), .en(adv2), .x(s1_x3), .q(rnd_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_fmt <= s1_fmt;
      s2_n1  <= s1_n1;
      s2_n2  <= s1_n2;
      s2_n3  <= s1_n3;
      s2_na  <= s1_na;
      s2_pad <= s1_pad;
    end
  end

  // stage 3: select result
  always_comb begin
    r_next   = '0;
    g_next   = '0;
    b_next   = '0;
    a_next   = '0;
    n1_next  = s2_n1;
    n2_next  = s2_n2;
    n3_next  = s2_n3;
    na_next  = s2_na;
    pad_next = 1'b0;
    unique case (s2_fmt)
      rpu_pkg::FMT_YVYU, rpu_pkg::FMT_Y210: begin
        r_next   = csc_r;
        g_next   = csc_g;
        b_next   = csc_b;
        a_next   = 8'hff;
        na_next  = '0;
        pad_next = s2_pad;
      end
      rpu_pkg::FMT_BGRA8, rpu_pkg::FMT_RGBA8: begin
        r_next = s2_n1[7:0];
        g_next = s2_n2[7:0];
        b_next = s2_n3[7:0];
        a_next = s2_na;
      end
      rpu_pkg::FMT_P2101010: begin
        r_next = rnd_r;
        g_next = rnd_g;
        b_next = rnd_b;
        a_next = {s2_na[1:0], s2_na[1:0], s2_na[1:0], s2_na[1:0]};
      end
      default: begin
        n1_next = '0;
        n2_next = '0;
        n3_next = '0;
        na_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      argb.red_out       <= r_next;
      argb.green_out     <= g_next;
      argb.blue_out      <= b_next;
      argb.alpha_out     <= a_next;
      argb.native_first  <= n1_next;
      argb.native_second <= n2_next;
      argb.native_third  <= n3_next;
      argb.native_alpha  <= na_next;
      argb.padding_clear <= pad_next;
    end
  end

  assign argb.valid = s3_valid;

endmodule

>>> rtl/rpu_csc.sv
`timescale 1ns / 1ps

module rpu_csc (
  input  logic                       clk,
  input  logic                       en,
  input  logic [7:0]                 c,
  input  logic signed [8:0]          d,
  input  logic signed [8:0]          e,
  output logic [rpu_pkg::COMP_W-1:0] red,
  output logic [rpu_pkg::COMP_W-1:0] green,
  output logic [rpu_pkg::COMP_W-1:0] blue
);

  logic signed [19:0] p_yc;
  logic signed [19:0] p_rv;
  logic signed [19:0] p_gu;
  logic signed [19:0] p_gv;
  logic signed [19:0] p_bu;
  logic signed [19:0] c_ext;
  logic signed [19:0] d_ext;
  logic signed [19:0] e_ext;
  logic signed [19:0] r_sum;
  logic signed [19:0] g_sum;
  logic signed [19:0] b_sum;

  function automatic logic [7:0] sat8(input logic signed [19:0] s);
    logic [7:0] v;
    if (s[19]) begin
      v = 8'd0;
    end else if (|s[18:16]) begin
      v = 8'hff;
    end else begin
      v = s[15:8];
    end
    return v;
  endfunction

  assign c_ext = $signed({12'b0, c});
  assign d_ext = $signed({{11{d[8]}}, d});
  assign e_ext = $signed({{11{e[8]}}, e});

  always_ff @(posedge clk) begin
    if (en) begin
      p_yc <= 20'sd298 * c_ext;
      p_rv <= 20'sd409 * e_ext;
      p_gu <= 20'sd100 * d_ext;
      p_gv <= 20'sd208 * e_ext;
      p_bu <= 20'sd516 * d_ext;
    end
  end

  assign r_sum = p_yc + p_rv + 20'sd128;
  assign g_sum = p_yc - p_gu - p_gv + 20'sd128;
  assign b_sum = p_yc + p_bu + 20'sd128;

  assign red   = sat8(r_sum);
  assign green = sat8(g_sum);
  assign blue  = sat8(b_sum);

endmodule

>>> rtl/rpu_round10.sv
`timescale 1ns / 1ps

module rpu_round10 (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rpu_pkg::RND_W-1:0]  x,
  output logic [rpu_pkg::COMP_W-1:0] q
);

  // x/1023 ~ x*1025 >> 20, low by one only when x is a multiple of 1023
  logic [28:0] prod;
  logic [7:0]  q_est;
  logic [18:0] q_1023;
  logic [18:0] rem_full;
  logic [7:0]  q_reg;
  logic [10:0] rem;

  assign prod     = {11'b0, x} + {1'b0, x, 10'b0};
  assign q_est    = prod[27:20];
  assign q_1023   = {1'b0, q_est, 10'b0} - {11'b0, q_est};
  assign rem_full = {1'b0, x} - q_1023;

  always_ff @(posedge clk) begin
    if (en) begin
      q_reg <= q_est;
      rem   <= rem_full[10:0];
    end
  end

  assign q = (rem >= 11'd1023) ? q_reg + 8'd1 : q_reg;

endmodule

>>> rtl/rpu_checker.sv
`timescale 1ns / 1ps

module rpu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic [7:0] alpha_out,
  input logic [9:0] native_first,
  input logic [9:0] native_second,
  input logic [9:0] native_third,
  input logic [7:0] native_alpha,
  input logic       padding_clear
);

  logic quiet;

  assign quiet = !(in_valid && in_ready) && out_ready;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out) && $stable(alpha_out) && $stable(native_first)
      && $stable(native_second) && $stable(native_third) && $stable(native_alpha)
      && $stable(padding_clear))
    else $error("result changed while stalled");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled with output open");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    quiet ##1 quiet ##1 quiet |=> !out_valid)
    else $error("result without a transfer in");

  a_pad_yuv: assert property (@(posedge clk) disable iff (rst)
    out_valid && padding_clear |-> alpha_out == 8'hff && native_alpha == 8'd0)
    else $error("padding flag outside YUV");

endmodule

bind raw_pixel_unpack_to_argb rpu_checker u_rpu_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (raw.valid),
  .in_ready      (raw.ready),
  .out_valid     (argb.valid),
  .out_ready     (argb.ready),
  .red_out       (argb.red_out),
  .green_out     (argb.green_out),
  .blue_out      (argb.blue_out),
  .alpha_out     (argb.alpha_out),
  .native_first  (argb.native_first),
  .native_second (argb.native_second),
  .native_third  (argb.native_third),
  .native_alpha  (argb.native_alpha),
  .padding_clear (argb.padding_clear)
);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import rpu_pkg::*;

  localparam logic [FMT_W-1:0] FMT_RSVD5 = 3'd5;
  localparam logic [FMT_W-1:0] FMT_RSVD6 = 3'd6;
  localparam logic [FMT_W-1:0] FMT_RSVD7 = 3'd7;

  localparam int RANDOM_ITEMS = 1230;
  localparam int CALM_ITEMS   = 120;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] alpha;
    logic [NAT_W-1:0]  nat1;
    logic [NAT_W-1:0]  nat2;
    logic [NAT_W-1:0]  nat3;
    logic [COMP_W-1:0] nat_a;
    logic              pad;
  } argb_px_t;

  typedef struct packed {
    logic              is_fmt;
    logic [FMT_W-1:0]  fmt;
    logic [RAW_W-1:0]  raw_word;
    logic              odd;
  } job_t;

  logic clk;
  logic rst;

  rpu_cfg_if  cfg_ch ();
  rpu_raw_if  raw_ch ();
  rpu_argb_if argb_ch ();

  raw_pixel_unpack_to_argb dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .raw  (raw_ch),
    .argb (argb_ch)
  );

  job_t             job_q[$];
  argb_px_t         argb_due[$];
  logic [FMT_W-1:0] fmt_now;
  int               errors;
  int               cyc;
  int               quiet;
  int               gap_left;
  int               drv_mode;
  int               stall_left;
  int               hold_left;
  bit               hold_done;
  int               mon_mode;
  int               results_seen;

  function automatic logic [7:0] sat8(input int sum);
    int v;
    if (sum < 0) return 8'd0;
    v = sum >>> 8;
    if (v > 255) return 8'hff;
    return v[7:0];
  endfunction

  function automatic logic [7:0] round8(input logic [NAT_W-1:0] v);
    int t;
    t = (int'(v) * 255 + 511) / 1023;
    return t[7:0];
  endfunction

  function automatic void yuv_to_rgb(input int y, input int u, input int v,
                                     output logic [7:0] r, output logic [7:0] g,
                                     output logic [7:0] b);
    int c, d, e;
    c = y - 16;
    if (c < 0) c = 0;
    d = u - 128;
    e = v - 128;
    r = sat8(298 * c + 409 * e + 128);
    g = sat8(298 * c - 100 * d - 208 * e + 128);
    b = sat8(298 * c + 516 * d + 128);
  endfunction

  function automatic argb_px_t unpack_pixel(input logic [RAW_W-1:0] w, input logic odd,
                                            input logic [FMT_W-1:0] fmt);
    argb_px_t    p;
    logic [15:0] wd[4];
    logic [7:0]  bt[4];
    logic [15:0] luma_w;
    logic [7:0]  r, g, b;
    p = '0;
    for (int i = 0; i < 4; i++) begin
      bt[i] = w[8*i +: 8];
      wd[i] = w[16*i +: 16];
    end
    case (fmt)
      FMT_YVYU: begin
        p.nat1 = {2'b00, odd ? bt[2] : bt[0]};
        p.nat2 = {2'b00, bt[3]};
        p.nat3 = {2'b00, bt[1]};
        yuv_to_rgb(int'(p.nat1), int'(p.nat2), int'(p.nat3), r, g, b);
        p.red = r; p.green = g; p.blue = b;
        p.alpha = 8'hff;
      end
      FMT_Y210: begin
        luma_w = odd ? wd[2] : wd[0];
        p.nat1 = luma_w[15:6];
        p.nat2 = wd[1][15:6];
        p.nat3 = wd[3][15:6];
        yuv_to_rgb(int'(p.nat1[9:2]), int'(p.nat2[9:2]), int'(p.nat3[9:2]), r, g, b);
        p.red = r; p.green = g; p.blue = b;
        p.alpha = 8'hff;
        p.pad = (((wd[0] | wd[1] | wd[2] | wd[3]) & 16'h003f) == 16'h0000);
      end
      FMT_BGRA8: begin
        p.nat3 = {2'b00, bt[0]};
        p.nat2 = {2'b00, bt[1]};
        p.nat1 = {2'b00, bt[2]};
        p.nat_a = bt[3];
        p.blue = bt[0]; p.green = bt[1]; p.red = bt[2]; p.alpha = bt[3];
      end
      FMT_RGBA8: begin
        p.nat1 = {2'b00, bt[0]};
        p.nat2 = {2'b00, bt[1]};
        p.nat3 = {2'b00, bt[2]};
        p.nat_a = bt[3];
        p.red = bt[0]; p.green = bt[1]; p.blue = bt[2]; p.alpha = bt[3];
      end
      FMT_P2101010: begin
        p.nat1 = w[9:0];
        p.nat2 = w[19:10];
        p.nat3 = w[29:20];
        p.nat_a = {6'b0, w[31:30]};
        p.red = round8(p.nat1);
        p.green = round8(p.nat2);
        p.blue = round8(p.nat3);
        p.alpha = p.nat_a * 8'd85;
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic queue_pixel(input logic [RAW_W-1:0] w, input logic odd);
    job_t j;
    j = '0;
    j.raw_word = w;
    j.odd = odd;
    job_q.push_back(j);
  endtask

  task automatic queue_format(input logic [FMT_W-1:0] fmt);
    job_t j;
    j = '0;
    j.is_fmt = 1'b1;
    j.fmt = fmt;
    job_q.push_back(j);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("** raw_pixel_unpack_to_argb: FAILED **");
      $finish;
    end
  end

  // driver: pixel items from job_q, format writes only once the pipe has drained
  always @(posedge clk) begin
    logic             n_valid;
    logic [RAW_W-1:0] n_word;
    logic             n_odd;
    logic             n_cfg_valid;
    logic [FMT_W-1:0] n_fmt;
    job_t             head;
    n_valid = raw_ch.valid;
    n_word = raw_ch.raw_word;
    n_odd = raw_ch.odd_pixel;
    n_cfg_valid = cfg_ch.valid;
    n_fmt = cfg_ch.pixel_format;
    if (rst) begin
      n_valid = 1'b0;
      n_cfg_valid = 1'b0;
      gap_left = 0;
      quiet = 0;
      fmt_now = FMT_YVYU;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        fmt_now = cfg_ch.pixel_format;
        n_cfg_valid = 1'b0;
      end
      if (raw_ch.valid && raw_ch.ready) begin
        argb_due.push_back(unpack_pixel(raw_ch.raw_word, raw_ch.odd_pixel, fmt_now));
        n_valid = 1'b0;
      end
      if (argb_due.size() == 0 && !raw_ch.valid) begin
        if (quiet < 1000) quiet++;
      end else begin
        quiet = 0;
      end
      if (cyc % 128 == 0) drv_mode = $urandom_range(0, 2);
      if (!n_valid && !n_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (job_q.size() > 0) begin
          head = job_q[0];
          if (head.is_fmt) begin
            if (quiet >= QUIET_CYCLES) begin
              void'(job_q.pop_front());
              n_cfg_valid = 1'b1;
              n_fmt = head.fmt;
            end
          end else if (job_q.size() > CALM_ITEMS && drv_mode != 0 &&
                       $urandom_range(0, (drv_mode == 1) ? 9 : 2) == 0) begin
            gap_left = $urandom_range(0, 4);
          end else begin
            void'(job_q.pop_front());
            n_valid = 1'b1;
            n_word = head.raw_word;
            n_odd = head.odd;
          end
        end
      end
    end
    raw_ch.valid <= n_valid;
    raw_ch.raw_word <= n_word;
    raw_ch.odd_pixel <= n_odd;
    cfg_ch.valid <= n_cfg_valid;
    cfg_ch.pixel_format <= n_fmt;
  end

  // monitor: checks each result transfer, drives ready with random stalls and one long hold
  always @(posedge clk) begin
    logic     n_ready;
    argb_px_t want;
    n_ready = argb_ch.ready;
    if (rst) begin
      n_ready = 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (argb_ch.valid && argb_ch.ready) begin
        results_seen++;
        if (argb_due.size() == 0) begin
          $error("result transfer with no expected pixel pending");
          errors++;
        end else begin
          want = argb_due.pop_front();
          check_field("red_out", int'(want.red), int'(argb_ch.red_out));
          check_field("green_out", int'(want.green), int'(argb_ch.green_out));
          check_field("blue_out", int'(want.blue), int'(argb_ch.blue_out));
          check_field("alpha_out", int'(want.alpha), int'(argb_ch.alpha_out));
          check_field("native_first", int'(want.nat1), int'(argb_ch.native_first));
          check_field("native_second", int'(want.nat2), int'(argb_ch.native_second));
          check_field("native_third", int'(want.nat3), int'(argb_ch.native_third));
          check_field("native_alpha", int'(want.nat_a), int'(argb_ch.native_alpha));
          check_field("padding_clear", int'(want.pad), int'(argb_ch.padding_clear));
        end
      end
      if (cyc % 96 == 0) mon_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        n_ready = 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        n_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        n_ready = 1'b0;
      end else if (job_q.size() > CALM_ITEMS && mon_mode != 0 &&
                   $urandom_range(0, (mon_mode == 1) ? 9 : 2) == 0) begin
        stall_left = $urandom_range(0, 4);
        n_ready = 1'b0;
      end else begin
        n_ready = 1'b1;
      end
    end
    argb_ch.ready <= n_ready;
  end

  initial begin
    int               n_items;
    int               len;
    logic [FMT_W-1:0] fmt;
    logic [RAW_W-1:0] w;
    int               pick;
    rst = 1'b1;
    errors = 0;
    cyc = 0;
    drv_mode = 0;
    mon_mode = 0;
    hold_done = 1'b0;
    results_seen = 0;
    fmt_now = FMT_YVYU;
    raw_ch.valid = 1'b0;
    raw_ch.raw_word = '0;
    raw_ch.odd_pixel = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.pixel_format = FMT_YVYU;
    argb_ch.ready = 1'b0;

    queue_format(FMT_YVYU);
    queue_pixel(64'h0, 1'b0);
    queue_pixel('1, 1'b1);
    queue_pixel(64'h0000_0000_80EB_8010, 1'b0);
    queue_pixel(64'h0000_0000_80EB_8010, 1'b1);
    queue_pixel(64'h0000_0000_FF00_0000, 1'b0);   // negative sums clamp to zero
    queue_format(FMT_Y210);
    queue_pixel(64'h0, 1'b0);
    queue_pixel('1, 1'b1);
    queue_pixel(64'h8000_EB00_8000_1000, 1'b1);
    queue_pixel(64'h8000_EB00_8001_1000, 1'b0);
    queue_format(FMT_BGRA8);
    queue_pixel(64'hDEAD_BEEF_1234_5678, 1'b1);
    queue_pixel('1, 1'b0);
    queue_format(FMT_RGBA8);
    queue_pixel(64'h0000_0000_89AB_CDEF, 1'b0);
    queue_pixel(64'hFFFF_FFFF_0000_0000, 1'b1);   // upper word ignored
    queue_format(FMT_P2101010);
    queue_pixel('1, 1'b0);
    queue_pixel(64'h0, 1'b1);
    queue_pixel(64'h1234_5678_8020_05FF, 1'b0);
    queue_format(FMT_RSVD5);
    queue_pixel('1, 1'b1);
    queue_format(FMT_RSVD6);
    queue_pixel(64'h5555_AAAA_5555_AAAA, 1'b1);
    queue_format(FMT_RSVD7);
    queue_pixel(64'hAAAA_5555_AAAA_5555, 1'b0);

    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) fmt = FMT_W'($urandom_range(FMT_RSVD5, FMT_RSVD7));
      else fmt = FMT_W'($urandom_range(FMT_YVYU, FMT_P2101010));
      queue_format(fmt);
      len = $urandom_range(30, 110);
      for (int k = 0; k < len; k++) begin
        w = {$urandom, $urandom};
        if (fmt == FMT_Y210 && $urandom_range(0, 1) == 1) w = w & 64'hFFC0_FFC0_FFC0_FFC0;
        if ($urandom_range(0, 7) == 0) begin
          pick = $urandom_range(0, 7);
          w[8*pick +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        end
        queue_pixel(w, 1'($urandom_range(0, 1)));
      end
      n_items += len;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (job_q.size() > 0 || raw_ch.valid || cfg_ch.valid || argb_due.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0 && argb_due.size() == 0) begin
      $display("** raw_pixel_unpack_to_argb: PASSED **");
    end else begin
      $display("** raw_pixel_unpack_to_argb: FAILED **");
    end
    $finish;
  end

endmodule
